// ----- hw/rtl/sfla_pkg.sv -----
// Shared constants and types for the staged free-list allocator.
package sfla_pkg;

    localparam int STAGE_CAPACITY_MAX = 1024;
    localparam int STAGE_COUNT_MAX    = 4;
    localparam int LINK_DEPTH         = STAGE_CAPACITY_MAX * STAGE_COUNT_MAX;
    localparam int FREE_COUNT_LIMIT   = 4096;

    localparam int HANDLE_W    = 18;
    localparam int STAGE_FLD_W = 8;
    localparam int ELEM_FLD_W  = 10;
    localparam int CAP_W       = 11;
    localparam int MAXST_W     = 3;
    localparam int STAGE_W     = 2;
    localparam int ELEM_W      = 10;
    localparam int LINK_AW     = STAGE_W + ELEM_W;
    localparam int HW_W        = 12;
    localparam int FCNT_W      = 13;
    localparam int CFG_DATA_W  = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;

    typedef logic [HANDLE_W-1:0] handle_t;

    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    typedef enum logic
    {
        REG_STAGE_CAPACITY = 1'b0,
        REG_MAX_STAGES     = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        STATUS_OK       = 1'b0,
        STATUS_NO_SPACE = 1'b1
    } status_t;

endpackage

// ----- hw/rtl/sfla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfla_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/staged_free_list_allocator_unit.sv -----
// Top level of the staged free-list allocator with its link-store RAM.
//
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      tuser: req_type; tdata: free_handle
// m_*      out  m_tvalid / m_tready      tuser: status; tdata: handle, high water, free count
// cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A request is accepted and its link-store read issued in ST_IDLE, then updated and its result registered in ST_EXEC.
// The registered link-store read port sets this split; a pop needs the stored link as its new head.
// Reset is asynchronous active low; the link store has no clearing pass.
// A request waits in the update cycle while the result register is still full.
module staged_free_list_allocator_unit
    import sfla_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [17:0] free_handle
    input  logic                  s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [17:0] alloc_handle, [29:18] high_water,
                                             // [42:30] free_count
    output logic                  m_tuser,   // [0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     stage_capacity_reg, stage_capacity_next;
    logic [MAXST_W-1:0]   max_stages_reg, max_stages_next;
    handle_t              free_head_reg, free_head_next;
    logic [STAGE_W-1:0]   cur_stage_reg, cur_stage_next;
    logic [CAP_W-1:0]     next_element_reg, next_element_next;
    logic [MAXST_W-1:0]   stages_open_reg, stages_open_next;
    logic [FCNT_W-1:0]    free_counter_reg, free_counter_next;
    logic                 req_reg, req_next;
    handle_t              fh_reg, fh_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    handle_t              m_handle_reg, m_handle_next;
    logic                 m_status_reg, m_status_next;
    logic [HW_W-1:0]      m_hw_reg, m_hw_next;
    logic [FCNT_W-1:0]    m_fc_reg, m_fc_next;

    logic                 s_beat;
    logic                 out_free;
    logic [CAP_W-1:0]     eff_cap;
    logic [MAXST_W-1:0]   eff_stages;
    logic                 rd_en;
    logic [LINK_AW-1:0]   rd_addr;
    handle_t              rd_data;
    logic                 wr_en;
    logic [LINK_AW-1:0]   wr_addr;
    logic [HW_W+1:0]      hw_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid & s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {(M_TDATA_W - HANDLE_W - HW_W - FCNT_W)'(0), m_fc_reg, m_hw_reg,
                       m_handle_reg};

    always_comb
    begin
        if (stage_capacity_reg == '0 || stage_capacity_reg > CAP_W'(STAGE_CAPACITY_MAX))
            eff_cap = CAP_W'(STAGE_CAPACITY_MAX);
        else
            eff_cap = stage_capacity_reg;
        if (max_stages_reg == '0 || max_stages_reg > MAXST_W'(STAGE_COUNT_MAX))
            eff_stages = MAXST_W'(STAGE_COUNT_MAX);
        else
            eff_stages = max_stages_reg;
    end

    assign rd_en   = s_beat && (req_type_t'(s_tuser) == REQ_ALLOC) && (free_head_reg != '0);
    assign rd_addr = {free_head_reg[STAGE_W-1:0],
                      free_head_reg[STAGE_FLD_W +: ELEM_W]};
    assign wr_addr = {fh_reg[STAGE_W-1:0], fh_reg[STAGE_FLD_W +: ELEM_W]};

    always_comb
    begin
        state_next          = state_reg;
        stage_capacity_next = stage_capacity_reg;
        max_stages_next     = max_stages_reg;
        free_head_next      = free_head_reg;
        cur_stage_next      = cur_stage_reg;
        next_element_next   = next_element_reg;
        stages_open_next    = stages_open_reg;
        free_counter_next   = free_counter_reg;
        req_next            = req_reg;
        fh_next             = fh_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_handle_next       = m_handle_reg;
        m_status_next       = m_status_reg;
        m_hw_next           = m_hw_reg;
        m_fc_next           = m_fc_reg;
        wr_en               = 1'b0;
        hw_sum              = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_STAGE_CAPACITY: stage_capacity_next = cfg_data[CAP_W-1:0];
                REG_MAX_STAGES:     max_stages_next     = cfg_data[MAXST_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                begin
                    req_next   = s_tuser;
                    fh_next    = s_tdata[HANDLE_W-1:0];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    m_handle_next = '0;
                    m_status_next = STATUS_OK;
                    if (req_type_t'(req_reg) == REQ_ALLOC)
                    begin
                        if (free_head_reg != '0)
                        begin
                            m_handle_next  = free_head_reg;
                            free_head_next = rd_data;
                            if (free_counter_reg != '0)
                                free_counter_next = free_counter_reg - FCNT_W'(1);
                        end
                        else if (next_element_reg >= eff_cap
                                 && stages_open_reg >= eff_stages)
                        begin
                            m_status_next = STATUS_NO_SPACE;
                        end
                        else
                        begin
                            if (next_element_reg >= eff_cap)
                            begin
                                stages_open_next = stages_open_reg + MAXST_W'(1);
                                cur_stage_next   = cur_stage_reg + STAGE_W'(1);
                                m_handle_next    = {ELEM_FLD_W'(0),
                                                    (STAGE_FLD_W - STAGE_W)'(0),
                                                    cur_stage_next};
                                next_element_next = CAP_W'(1);
                            end
                            else
                            begin
                                m_handle_next     = {next_element_reg[ELEM_W-1:0],
                                                     (STAGE_FLD_W - STAGE_W)'(0),
                                                     cur_stage_reg};
                                next_element_next = next_element_reg + CAP_W'(1);
                            end
                        end
                    end
                    else if (fh_reg != '0
                             && fh_reg[STAGE_FLD_W-1:0] < STAGE_FLD_W'(STAGE_COUNT_MAX))
                    begin
                        wr_en          = 1'b1;
                        free_head_next = fh_reg;
                        if (free_counter_reg < FCNT_W'(FREE_COUNT_LIMIT))
                            free_counter_next = free_counter_reg + FCNT_W'(1);
                    end
                    hw_sum = (HW_W+2)'(cur_stage_next) * (HW_W+2)'(eff_cap)
                           + (HW_W+2)'(next_element_next) - (HW_W+2)'(1);
                    m_hw_next     = hw_sum[HW_W-1:0];
                    m_fc_next     = free_counter_next;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            stage_capacity_reg <= CAP_W'(STAGE_CAPACITY_MAX);
            max_stages_reg     <= MAXST_W'(STAGE_COUNT_MAX);
            free_head_reg      <= '0;
            cur_stage_reg      <= '0;
            next_element_reg   <= CAP_W'(1);
            stages_open_reg    <= MAXST_W'(1);
            free_counter_reg   <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            stage_capacity_reg <= stage_capacity_next;
            max_stages_reg     <= max_stages_next;
            free_head_reg      <= free_head_next;
            cur_stage_reg      <= cur_stage_next;
            next_element_reg   <= next_element_next;
            stages_open_reg    <= stages_open_next;
            free_counter_reg   <= free_counter_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        fh_reg       <= fh_next;
        m_handle_reg <= m_handle_next;
        m_status_reg <= m_status_next;
        m_hw_reg     <= m_hw_next;
        m_fc_reg     <= m_fc_next;
    end

    sfla_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (free_head_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
